### rtl/chq_pkg.sv
package chq_pkg;

  localparam int DOUBLE_ROUNDS = 10;
  localparam int HALF_ROUNDS   = 2 * DOUBLE_ROUNDS;
  localparam logic [4:0] LAST_HALF = 5'(HALF_ROUNDS - 1);

  localparam logic [31:0] SIGMA_0 = 32'h61707865;
  localparam logic [31:0] SIGMA_1 = 32'h3320646e;
  localparam logic [31:0] SIGMA_2 = 32'h79622d32;
  localparam logic [31:0] SIGMA_3 = 32'h6b206574;

  localparam logic [2:0] CFG_KEY_01   = 3'd0;
  localparam logic [2:0] CFG_KEY_23   = 3'd1;
  localparam logic [2:0] CFG_KEY_45   = 3'd2;
  localparam logic [2:0] CFG_KEY_67   = 3'd3;
  localparam logic [2:0] CFG_NONCE_01 = 3'd4;
  localparam logic [2:0] CFG_NONCE_2  = 3'd5;

  // quarter-round sub-steps
  localparam logic [1:0] SUB_AB16 = 2'd0;
  localparam logic [1:0] SUB_CD12 = 2'd1;
  localparam logic [1:0] SUB_AB8  = 2'd2;
  localparam logic [1:0] SUB_CD7  = 2'd3;

  typedef logic [15:0][31:0] word_vec_t;

  typedef enum logic [2:0] {
    S_IDLE  = 3'b001,
    S_ROUND = 3'b010,
    S_EMIT  = 3'b100
  } fsm_t;

  typedef struct packed {
    logic       load;
    logic       qr_en;
    logic [1:0] sub;
    logic       permute;
    logic       unpermute;
    logic       shift;
  } chq_ctl_t;

endpackage

### rtl/chq_qr_step.sv
module chq_qr_step import chq_pkg::*; (
  input  logic [1:0]  sub,
  input  logic [31:0] x,
  input  logic [31:0] y,
  input  logic [31:0] z,
  output logic [31:0] x_new,
  output logic [31:0] z_new
);

  logic [31:0] mix;

  assign x_new = x + y;
  assign mix   = z ^ x_new;

  always_comb begin
    case (sub)
      SUB_AB16: z_new = {mix[15:0], mix[31:16]};
      SUB_CD12: z_new = {mix[19:0], mix[31:20]};
      SUB_AB8:  z_new = {mix[23:0], mix[31:24]};
      SUB_CD7:  z_new = {mix[24:0], mix[31:25]};
      default:  z_new = mix;
    endcase
  end

endmodule

### rtl/chq_state.sv
module chq_state import chq_pkg::*; (
  input  logic        clk,
  input  chq_ctl_t    ctl,
  input  word_vec_t   load_vec,
  output logic [31:0] head_word
);

  word_vec_t st_r;
  word_vec_t st_nxt;
  word_vec_t qr_vec;
  logic [3:0][31:0] x_in, y_in, z_in, x_out, z_out;

  // lanes always work on columns: diagonal rounds run on a row-rotated state
  for (genvar c = 0; c < 4; c++) begin : g_lane
    always_comb begin
      if (ctl.sub[0]) begin
        x_in[c] = st_r[8 + c];
        y_in[c] = st_r[12 + c];
        z_in[c] = st_r[4 + c];
      end else begin
        x_in[c] = st_r[c];
        y_in[c] = st_r[4 + c];
        z_in[c] = st_r[12 + c];
      end
    end

    chq_qr_step u_qr (
      .sub   (ctl.sub),
      .x     (x_in[c]),
      .y     (y_in[c]),
      .z     (z_in[c]),
      .x_new (x_out[c]),
      .z_new (z_out[c])
    );
  end

  always_comb begin
    qr_vec = st_r;
    for (int c = 0; c < 4; c++) begin
      if (ctl.sub[0]) begin
        qr_vec[8 + c] = x_out[c];
        qr_vec[4 + c] = z_out[c];
      end else begin
        qr_vec[c]      = x_out[c];
        qr_vec[12 + c] = z_out[c];
      end
    end
  end

  always_comb begin
    st_nxt = st_r;
    if (ctl.load) begin
      st_nxt = load_vec;
    end else if (ctl.qr_en) begin
      st_nxt = qr_vec;
      if (ctl.permute) begin
        for (int r = 0; r < 4; r++) begin
          for (int j = 0; j < 4; j++) begin
            st_nxt[r * 4 + j] = qr_vec[r * 4 + ((j + r) % 4)];
          end
        end
      end else if (ctl.unpermute) begin
        for (int r = 0; r < 4; r++) begin
          for (int j = 0; j < 4; j++) begin
            st_nxt[r * 4 + j] = qr_vec[r * 4 + ((j + 4 - r) % 4)];
          end
        end
      end
    end else if (ctl.shift) begin
      for (int i = 0; i < 15; i++) begin
        st_nxt[i] = st_r[i + 1];
      end
    end
  end

  always_ff @(posedge clk) begin
    st_r <= st_nxt;
  end

  assign head_word = st_r[0];

endmodule

### rtl/chacha20_keystream_block.sv
// chacha20 keystream block generator
// configuration: write cfg_wdata to register cfg_index with cfg_we. registers 0 to 3
// hold key words 0/1 .. 6/7, register 4 nonce words 0/1, register 5 nonce word 2
// (low half of cfg_wdata). higher indexes are ignored. write only while busy is low.
// input: a block counter is taken when start is high and busy is low.
// output: sixteen beats, one per cycle, marked by out_valid: keystream word,
// its index 0..15 and out_last_word on index 15.
// the state loads at the accepting edge, then the rounds follow (20 half rounds of
// four quarter-round sub-steps, four column lanes each with its own add/xor/rotate
// step), then the output words, each beat registered from the emit state.
// busy drops with the last word so start may be taken again right then.
// the final add of the initial state is done per word on the output path.
// reset returns the sequencer to idle and zeroes the counters, output strobe, key,
// nonce and counter copy registers; state words and output data are not reset.
// the receiver cannot stall: each beat is valid for exactly one cycle.
module chacha20_keystream_block import chq_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  logic [31:0] in_block_counter,
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [63:0] cfg_wdata,
  output logic        out_valid,
  output logic [31:0] out_keystream_word,
  output logic [3:0]  out_word_index,
  output logic        out_last_word
);

  fsm_t        state_r, state_nxt;
  logic [4:0]  half_r, half_nxt;
  logic [1:0]  sub_r, sub_nxt;
  logic [3:0]  emit_r, emit_nxt;
  logic [31:0] counter_copy_r;
  logic [63:0] key01_r, key23_r, key45_r, key67_r, nonce01_r;
  logic [31:0] nonce2_r;
  logic        out_valid_r;
  logic [31:0] out_word_r;
  logic [3:0]  out_index_r;
  logic        out_last_r;
  logic        accept;
  chq_ctl_t    ctl;
  word_vec_t   load_vec;
  word_vec_t   init_vec;
  logic [31:0] head_word;

  function automatic word_vec_t build_init(input logic [63:0] k01, input logic [63:0] k23,
                                           input logic [63:0] k45, input logic [63:0] k67,
                                           input logic [31:0] ctr, input logic [63:0] n01,
                                           input logic [31:0] n2);
    word_vec_t v;
    v[0]  = SIGMA_0;
    v[1]  = SIGMA_1;
    v[2]  = SIGMA_2;
    v[3]  = SIGMA_3;
    v[4]  = k01[31:0];
    v[5]  = k01[63:32];
    v[6]  = k23[31:0];
    v[7]  = k23[63:32];
    v[8]  = k45[31:0];
    v[9]  = k45[63:32];
    v[10] = k67[31:0];
    v[11] = k67[63:32];
    v[12] = ctr;
    v[13] = n01[31:0];
    v[14] = n01[63:32];
    v[15] = n2;
    return v;
  endfunction

  assign busy   = (state_r != S_IDLE);
  assign accept = start && !busy;

  assign load_vec = build_init(key01_r, key23_r, key45_r, key67_r, in_block_counter,
                               nonce01_r, nonce2_r);
  assign init_vec = build_init(key01_r, key23_r, key45_r, key67_r, counter_copy_r,
                               nonce01_r, nonce2_r);

  always_comb begin
    state_nxt = state_r;
    half_nxt  = half_r;
    sub_nxt   = sub_r;
    emit_nxt  = emit_r;
    ctl       = '0;
    ctl.sub   = sub_r;
    case (state_r)
      S_IDLE: begin
        if (accept) begin
          ctl.load  = 1'b1;
          state_nxt = S_ROUND;
          half_nxt  = '0;
          sub_nxt   = SUB_AB16;
        end
      end
      S_ROUND: begin
        ctl.qr_en = 1'b1;
        sub_nxt   = sub_r + 2'd1;
        if (sub_r == SUB_CD7) begin
          ctl.permute   = !half_r[0];
          ctl.unpermute = half_r[0];
          half_nxt      = half_r + 5'd1;
          if (half_r == LAST_HALF) begin
            half_nxt  = '0;
            emit_nxt  = '0;
            state_nxt = S_EMIT;
          end
        end
      end
      S_EMIT: begin
        ctl.shift = 1'b1;
        emit_nxt  = emit_r + 4'd1;
        if (emit_r == 4'hf) begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  chq_state u_state (
    .clk       (clk),
    .ctl       (ctl),
    .load_vec  (load_vec),
    .head_word (head_word)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r        <= S_IDLE;
      half_r         <= '0;
      sub_r          <= '0;
      emit_r         <= '0;
      counter_copy_r <= '0;
      key01_r        <= '0;
      key23_r        <= '0;
      key45_r        <= '0;
      key67_r        <= '0;
      nonce01_r      <= '0;
      nonce2_r       <= '0;
      out_valid_r    <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      half_r      <= half_nxt;
      sub_r       <= sub_nxt;
      emit_r      <= emit_nxt;
      out_valid_r <= (state_r == S_EMIT);
      if (accept) begin
        counter_copy_r <= in_block_counter;
      end
      if (cfg_we) begin
        case (cfg_index)
          CFG_KEY_01:   key01_r   <= cfg_wdata;
          CFG_KEY_23:   key23_r   <= cfg_wdata;
          CFG_KEY_45:   key45_r   <= cfg_wdata;
          CFG_KEY_67:   key67_r   <= cfg_wdata;
          CFG_NONCE_01: nonce01_r <= cfg_wdata;
          CFG_NONCE_2:  nonce2_r  <= cfg_wdata[31:0];
          default: begin
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == S_EMIT) begin
      out_word_r  <= head_word + init_vec[emit_r];
      out_index_r <= emit_r;
      out_last_r  <= (emit_r == 4'hf);
    end
  end

  assign out_valid          = out_valid_r;
  assign out_keystream_word = out_word_r;
  assign out_word_index     = out_index_r;
  assign out_last_word      = out_last_r;

  a_state_onehot: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot(state_r)) else $error("sequencer state not one-hot");

  a_accept_starts_rounds: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> (state_r == S_ROUND) && (half_r == 5'd0) && (sub_r == SUB_AB16))
    else $error("accepted block did not start rounds");

  a_emit_after_rounds: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(state_r == S_EMIT) |-> $past(half_r) == LAST_HALF && $past(sub_r) == SUB_CD7)
    else $error("output began before all rounds finished");

  a_last_ends_block: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_EMIT) && (emit_r == 4'hf) |=> (state_r == S_IDLE) && out_valid_r)
    else $error("block did not end after word 15");

  a_out_from_emit: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> $past(state_r == S_EMIT))
    else $error("output beat outside emit phase");

endmodule
